// ===== rtl/core/gpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_pkg: shared types and constants for the greedy priority tour core
// Field widths, state encodings, distance unit request/response and the
// CORDIC arctangent table (Q24 degrees).
// ----------------------------------------------------------------------------
package gpt_pkg;

    localparam int MAX_CITIES   = 32;
    localparam int IDX_W        = $clog2(MAX_CITIES);
    localparam int CNT_W        = $clog2(MAX_CITIES + 1);
    localparam int LAT_W        = 24;
    localparam int LON_W        = 25;
    localparam int PRIO_W       = 8;
    localparam int OIDX_W       = 6;
    localparam int DIST_W       = 28;
    localparam int LEG_W        = 23;
    localparam int CFG_W        = 25;
    localparam int CW           = 34;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 31;

    localparam logic signed [LAT_W-1:0] CENTRE_LAT_RST = 24'sd3422023;
    localparam logic signed [LON_W-1:0] CENTRE_LON_RST = 25'sd1253994;

    typedef enum logic [0:0] {
        CFG_CENTRE_LAT = 1'b0,
        CFG_CENTRE_LON = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_WAIT,
        S_SCAN_LEG,
        S_PICK,
        S_CHECK,
        S_RET_LEG
    } t_top_state;

    typedef enum logic [3:0] {
        L_IDLE,
        L_RINIT,
        L_ROT,
        L_RFIN,
        L_MUL,
        L_MWB,
        L_SQRT,
        L_AINIT,
        L_ATAN,
        L_AFIN,
        L_SCALE,
        L_RND,
        L_DONE
    } t_leg_state;

    typedef enum logic [2:0] {
        PH_DLAT,
        PH_DLON,
        PH_LAT1,
        PH_LAT2,
        PH_MIX
    } t_leg_phase;

    typedef struct packed {
        logic                    start;
        logic signed [LAT_W-1:0] lat1;
        logic signed [LON_W-1:0] lon1;
        logic signed [LAT_W-1:0] lat2;
        logic signed [LON_W-1:0] lon2;
    } t_leg_req;

    typedef struct packed {
        logic             done;
        logic [LEG_W-1:0] leg_len;
    } t_leg_rsp;

    function automatic logic signed [CW-1:0] cordic_atan(input logic [4:0] k);
        logic signed [CW-1:0] v;
        case (k)
            5'd0:    v = 34'sd754974720;
            5'd1:    v = 34'sd445687602;
            5'd2:    v = 34'sd235489088;
            5'd3:    v = 34'sd119537938;
            5'd4:    v = 34'sd60000934;
            5'd5:    v = 34'sd30029717;
            5'd6:    v = 34'sd15018523;
            5'd7:    v = 34'sd7509720;
            5'd8:    v = 34'sd3754917;
            5'd9:    v = 34'sd1877466;
            5'd10:   v = 34'sd938734;
            5'd11:   v = 34'sd469367;
            5'd12:   v = 34'sd234684;
            5'd13:   v = 34'sd117342;
            5'd14:   v = 34'sd58671;
            5'd15:   v = 34'sd29335;
            5'd16:   v = 34'sd14668;
            5'd17:   v = 34'sd7334;
            5'd18:   v = 34'sd3667;
            5'd19:   v = 34'sd1833;
            5'd20:   v = 34'sd917;
            5'd21:   v = 34'sd458;
            5'd22:   v = 34'sd229;
            5'd23:   v = 34'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/gpt_leg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_leg: haversine distance unit
// One shared CORDIC rotator, one shared multiplier, a pair of bit-serial
// square roots and a CORDIC vectoring pass. Result in 1/256 km.
// ----------------------------------------------------------------------------
module gpt_leg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gpt_pkg::t_leg_req i_req,
    output gpt_pkg::t_leg_rsp o_rsp
);
    import gpt_pkg::*;

    localparam logic signed [CW:0]   D90   = 35'sd1509949440;
    localparam logic signed [CW:0]   D180  = 35'sd3019898880;
    localparam logic signed [CW:0]   D360  = 35'sd6039797760;
    localparam logic signed [CW-1:0] X0    = 34'sd652032874;
    localparam logic signed [CW-1:0] Z90   = 34'sd1509949440;
    localparam logic signed [32:0]   KLEG  = 33'sd3731082605;
    localparam logic [30:0]          Q_ONE = 31'd1073741824;

    t_leg_state r_state, n_state;
    t_leg_phase r_phase;
    logic [4:0] r_iter;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic r_neg;
    logic signed [CW-1:0] r_c, r_s, r_c1, r_sl, r_sn, r_cc;
    logic signed [65:0] r_prod;
    logic [61:0] r_va, r_vb;
    logic [34:0] r_rema, r_remb;
    logic [30:0] r_roota, r_rootb;
    logic [LEG_W-1:0] r_dist;

    logic signed [LAT_W:0]   dlat;
    logic signed [LON_W:0]   dlon;
    logic signed [CW-1:0]    ang;
    logic signed [CW:0]      z0, z1, z2;
    logic                    neg;
    logic signed [CW-1:0]    dx, dy, atn, cval, sval, p30;
    logic signed [32:0]      mul_a, mul_b;
    logic signed [CW:0]      asum;
    logic [30:0]             a31;
    logic [65:0]             sqa, sqb;
    logic signed [65:0]      rnd;

    function automatic logic [65:0] isq_step(input logic [34:0] rem,
                                             input logic [30:0] root,
                                             input logic [1:0]  bits);
        logic [34:0] remx, trial;
        remx  = {rem[32:0], bits};
        trial = {2'b00, root, 2'b01};
        if (remx >= trial) begin
            return {remx - trial, root[29:0], 1'b1};
        end
        return {remx, root[29:0], 1'b0};
    endfunction

    // angle select and range reduction to [-90, 90] degrees
    always_comb begin
        dlat = (LAT_W+1)'(i_req.lat2) - (LAT_W+1)'(i_req.lat1);
        dlon = (LON_W+1)'(i_req.lon2) - (LON_W+1)'(i_req.lon1);
        case (r_phase)
            PH_DLAT: ang = CW'(dlat) <<< 7;
            PH_DLON: ang = CW'(dlon) <<< 7;
            PH_LAT1: ang = CW'(i_req.lat1) <<< 8;
            PH_LAT2: ang = CW'(i_req.lat2) <<< 8;
            default: ang = '0;
        endcase
        z0 = (CW+1)'(ang);
        if (z0 > D180) begin
            z1 = z0 - D360;
        end else if (z0 <= -D180) begin
            z1 = z0 + D360;
        end else begin
            z1 = z0;
        end
        neg = 1'b0;
        if (z1 > D90) begin
            z2  = z1 - D180;
            neg = 1'b1;
        end else if (z1 < -D90) begin
            z2  = z1 + D180;
            neg = 1'b1;
        end else begin
            z2 = z1;
        end
    end

    always_comb begin
        dx   = r_y >>> r_iter;
        dy   = r_x >>> r_iter;
        atn  = cordic_atan(r_iter);
        cval = r_neg ? -r_x : r_x;
        sval = r_neg ? -r_y : r_y;
        p30  = CW'(r_prod >>> 30);
        asum = (CW+1)'(r_sl) + (CW+1)'(p30);
        if (asum[CW]) begin
            a31 = '0;
        end else if (asum > (CW+1)'(Q_ONE)) begin
            a31 = Q_ONE;
        end else begin
            a31 = asum[30:0];
        end
        sqa = isq_step(r_rema, r_roota, r_va[61:60]);
        sqb = isq_step(r_remb, r_rootb, r_vb[61:60]);
        rnd = r_prod + (66'sd1 <<< 39);
    end

    // shared multiplier operands
    always_comb begin
        if (r_state == L_SCALE) begin
            mul_a = 33'(r_z);
            mul_b = KLEG;
        end else begin
            case (r_phase)
                PH_LAT2: begin
                    mul_a = 33'(r_c1);
                    mul_b = 33'(r_c);
                end
                PH_MIX: begin
                    mul_a = 33'(r_cc);
                    mul_b = 33'(r_sn);
                end
                default: begin
                    mul_a = 33'(r_s);
                    mul_b = 33'(r_s);
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE:  if (i_req.start) n_state = L_RINIT;
            L_RINIT: n_state = L_ROT;
            L_ROT:   if (r_iter == 5'(CORDIC_STEPS - 1)) n_state = L_RFIN;
            L_RFIN:  n_state = (r_phase == PH_LAT1) ? L_RINIT : L_MUL;
            L_MUL:   n_state = L_MWB;
            L_MWB: begin
                case (r_phase)
                    PH_LAT2: n_state = L_MUL;
                    PH_MIX:  n_state = L_SQRT;
                    default: n_state = L_RINIT;
                endcase
            end
            L_SQRT:  if (r_iter == 5'(SQRT_STEPS - 1)) n_state = L_AINIT;
            L_AINIT: n_state = L_ATAN;
            L_ATAN:  if (r_iter == 5'(CORDIC_STEPS - 1)) n_state = L_AFIN;
            L_AFIN:  n_state = L_SCALE;
            L_SCALE: n_state = L_RND;
            L_RND:   n_state = L_DONE;
            L_DONE:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done    = (r_state == L_DONE);
        o_rsp.leg_len = r_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_phase <= PH_DLAT;
        end else begin
            r_state <= n_state;
            case (r_state)
                L_IDLE: r_phase <= PH_DLAT;
                L_RFIN: if (r_phase == PH_LAT1) r_phase <= PH_LAT2;
                L_MWB: begin
                    case (r_phase)
                        PH_DLAT: r_phase <= PH_DLON;
                        PH_DLON: r_phase <= PH_LAT1;
                        PH_LAT2: r_phase <= PH_MIX;
                        default: r_phase <= r_phase;
                    endcase
                end
                default: r_phase <= r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_RINIT: begin
                r_x    <= X0;
                r_y    <= '0;
                r_z    <= CW'(z2);
                r_neg  <= neg;
                r_iter <= '0;
            end
            L_ROT: begin
                if (!r_z[CW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atn;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atn;
                end
                r_iter <= r_iter + 5'd1;
            end
            L_RFIN: begin
                r_c <= cval;
                r_s <= sval;
                if (r_phase == PH_LAT1) r_c1 <= cval;
            end
            L_MUL, L_SCALE: r_prod <= mul_a * mul_b;
            L_MWB: begin
                case (r_phase)
                    PH_DLAT: r_sl <= p30;
                    PH_DLON: r_sn <= p30;
                    PH_LAT2: r_cc <= p30;
                    default: begin
                        r_va    <= {1'b0, a31, 30'b0};
                        r_vb    <= {1'b0, Q_ONE - a31, 30'b0};
                        r_rema  <= '0;
                        r_remb  <= '0;
                        r_roota <= '0;
                        r_rootb <= '0;
                        r_iter  <= '0;
                    end
                endcase
            end
            L_SQRT: begin
                r_rema  <= sqa[65:31];
                r_roota <= sqa[30:0];
                r_remb  <= sqb[65:31];
                r_rootb <= sqb[30:0];
                r_va    <= {r_va[59:0], 2'b00};
                r_vb    <= {r_vb[59:0], 2'b00};
                r_iter  <= r_iter + 5'd1;
            end
            L_AINIT: begin
                r_x    <= CW'(r_rootb);
                r_y    <= CW'(r_roota);
                r_z    <= '0;
                r_iter <= '0;
            end
            L_ATAN: begin
                if (!r_y[CW-1] && (r_y != '0)) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atn;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atn;
                end
                r_iter <= r_iter + 5'd1;
            end
            L_AFIN: begin
                if (r_z[CW-1]) begin
                    r_z <= '0;
                end else if (r_z > Z90) begin
                    r_z <= Z90;
                end
            end
            L_RND: r_dist <= rnd[40+LEG_W-1:40];
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/greedy_priority_tour_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_priority_tour_core: priority-first nearest-neighbour tour
// Stores cities in a 32-entry memory, then walks a greedy tour and emits
// the visited city indices followed by the closing return with its length.
// ----------------------------------------------------------------------------
// Loading: one city per cycle; busy stays low until the flagged last city.
// Each distance is computed in the single gpt_leg unit (four CORDIC
// rotations, square root pair, CORDIC vectoring); a tour of n cities needs at
// most n + n(n-1)/2 + 1 distances, fewer when priority rules a candidate out.
// Results leave through a strobe register in the cycle after they are chosen.
// Synchronous active-low reset clears control state and visited marks.
module greedy_priority_tour_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [gpt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [gpt_pkg::LAT_W-1:0] i_latitude,
    input  logic signed [gpt_pkg::LON_W-1:0] i_longitude,
    input  logic [gpt_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic                          i_last_city,
    output logic                          o_valid,
    output logic [gpt_pkg::OIDX_W-1:0]    o_city_index,
    output logic                          o_is_last,
    output logic [gpt_pkg::DIST_W-1:0]    o_total_distance
);
    import gpt_pkg::*;

    localparam int MW = LAT_W + LON_W + PRIO_W;

    t_top_state r_state, n_state;

    logic [MW-1:0] r_mem [MAX_CITIES];
    logic [MW-1:0] r_rd;

    logic signed [LAT_W-1:0] r_centre_lat;
    logic signed [LON_W-1:0] r_centre_lon;
    logic [CNT_W-1:0] r_count, r_n, r_i, r_steps;
    logic [MAX_CITIES-1:0] r_visited;
    logic r_found, r_start_mode;
    logic [IDX_W-1:0] r_best_idx, r_cand_idx, r_start_idx;
    logic [PRIO_W-1:0] r_best_prio, r_cand_prio;
    logic [LEG_W-1:0] r_best_d;
    logic signed [LAT_W-1:0] r_best_lat, r_start_lat, r_p1_lat, r_p2_lat;
    logic signed [LON_W-1:0] r_best_lon, r_start_lon, r_p1_lon, r_p2_lon;
    logic [DIST_W-1:0] r_sum;
    logic r_valid, r_last;
    logic [OIDX_W-1:0] r_idx;
    logic [DIST_W-1:0] r_total;

    logic accept, store, skip, better, leg_start, emit, emit_last;
    logic [CNT_W-1:0] count_inc;
    logic [IDX_W-1:0] emit_idx;
    logic [DIST_W-1:0] emit_total, sum_ret, sum_pick;
    logic signed [LAT_W-1:0] rd_lat;
    logic signed [LON_W-1:0] rd_lon;
    logic [PRIO_W-1:0] rd_prio;
    t_leg_req leg_req;
    t_leg_rsp leg_rsp;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] s,
                                                  input logic [LEG_W-1:0]  d);
        logic [DIST_W:0] t;
        t = {1'b0, s} + (DIST_W+1)'(d);
        return t[DIST_W] ? {DIST_W{1'b1}} : t[DIST_W-1:0];
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign store  = (r_count < CNT_W'(MAX_CITIES));
    assign count_inc = store ? r_count + CNT_W'(1) : r_count;

    assign rd_lat  = r_rd[MW-1 -: LAT_W];
    assign rd_lon  = r_rd[PRIO_W +: LON_W];
    assign rd_prio = r_rd[PRIO_W-1:0];

    assign skip   = r_found && (rd_prio > r_best_prio);
    assign better = !r_found || (r_cand_prio < r_best_prio) ||
                    ((r_cand_prio == r_best_prio) && (leg_rsp.leg_len < r_best_d));
    assign sum_ret  = sat_add(r_sum, leg_rsp.leg_len);
    assign sum_pick = sat_add(r_sum, r_best_d);

    assign leg_req.start = leg_start;
    assign leg_req.lat1  = r_p1_lat;
    assign leg_req.lon1  = r_p1_lon;
    assign leg_req.lat2  = r_p2_lat;
    assign leg_req.lon2  = r_p2_lon;

    gpt_leg u_leg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (leg_req),
        .o_rsp   (leg_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_latitude, i_longitude, i_priority_req};
        end
        r_rd <= r_mem[r_i[IDX_W-1:0]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (accept && i_last_city) n_state = S_SCAN_RD;
            S_SCAN_RD: begin
                if (r_i == r_n) begin
                    n_state = S_PICK;
                end else if (!r_visited[r_i[IDX_W-1:0]]) begin
                    n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: n_state = skip ? S_SCAN_RD : S_SCAN_LEG;
            S_SCAN_LEG:  if (leg_rsp.done) n_state = S_SCAN_RD;
            S_PICK:      n_state = S_CHECK;
            S_CHECK:     n_state = (r_steps < r_n) ? S_SCAN_RD : S_RET_LEG;
            S_RET_LEG:   if (leg_rsp.done) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        leg_start  = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        emit_idx   = r_best_idx;
        emit_total = '0;
        case (r_state)
            S_SCAN_WAIT: leg_start = !skip;
            S_CHECK:     leg_start = !(r_steps < r_n);
            S_PICK:      emit = r_start_mode || r_found;
            S_RET_LEG: begin
                emit       = leg_rsp.done;
                emit_last  = 1'b1;
                emit_idx   = r_start_idx;
                emit_total = sum_ret;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_centre_lat <= CENTRE_LAT_RST;
            r_centre_lon <= CENTRE_LON_RST;
            r_count      <= '0;
            r_visited    <= '0;
            r_valid      <= 1'b0;
            r_found      <= 1'b0;
            r_start_mode <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= emit;
            if (i_cfg_wr) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CENTRE_LAT: r_centre_lat <= i_cfg_data[LAT_W-1:0];
                    CFG_CENTRE_LON: r_centre_lon <= i_cfg_data[LON_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_last_city) begin
                            r_n          <= count_inc;
                            r_count      <= '0;
                            r_i          <= '0;
                            r_found      <= 1'b0;
                            r_start_mode <= 1'b1;
                            r_visited    <= '0;
                            r_sum        <= '0;
                            r_p1_lat     <= r_centre_lat;
                            r_p1_lon     <= r_centre_lon;
                        end else begin
                            r_count <= count_inc;
                        end
                    end
                end
                S_SCAN_RD: begin
                    if ((r_i != r_n) && r_visited[r_i[IDX_W-1:0]]) r_i <= r_i + CNT_W'(1);
                end
                S_SCAN_WAIT: begin
                    if (skip) begin
                        r_i <= r_i + CNT_W'(1);
                    end else begin
                        r_p2_lat    <= rd_lat;
                        r_p2_lon    <= rd_lon;
                        r_cand_prio <= rd_prio;
                        r_cand_idx  <= r_i[IDX_W-1:0];
                    end
                end
                S_SCAN_LEG: begin
                    if (leg_rsp.done) begin
                        if (better) begin
                            r_best_idx  <= r_cand_idx;
                            r_best_prio <= r_cand_prio;
                            r_best_d    <= leg_rsp.leg_len;
                            r_best_lat  <= r_p2_lat;
                            r_best_lon  <= r_p2_lon;
                        end
                        r_found <= 1'b1;
                        r_i     <= r_i + CNT_W'(1);
                    end
                end
                S_PICK: begin
                    if (r_start_mode || r_found) begin
                        r_visited[r_best_idx] <= 1'b1;
                        r_p1_lat <= r_best_lat;
                        r_p1_lon <= r_best_lon;
                    end
                    if (r_start_mode) begin
                        r_start_mode <= 1'b0;
                        r_start_idx  <= r_best_idx;
                        r_start_lat  <= r_best_lat;
                        r_start_lon  <= r_best_lon;
                        r_steps      <= CNT_W'(1);
                    end else if (r_found) begin
                        r_sum   <= sum_pick;
                        r_steps <= r_steps + CNT_W'(1);
                    end else begin
                        r_steps <= r_n;
                    end
                end
                S_CHECK: begin
                    if (r_steps < r_n) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                    end else begin
                        r_p2_lat <= r_start_lat;
                        r_p2_lon <= r_start_lon;
                    end
                end
                S_RET_LEG: if (leg_rsp.done) r_sum <= sum_ret;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_idx   <= OIDX_W'(emit_idx);
            r_last  <= emit_last;
            r_total <= emit_total;
        end
    end

    assign o_valid          = r_valid;
    assign o_city_index     = r_idx;
    assign o_is_last        = r_last;
    assign o_total_distance = r_total;

endmodule

// ===== rtl/core/gpt_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_chk: port-level checks for greedy_priority_tour_core
// Relates request acceptance, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module gpt_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_wr,
    input logic [0:0]                    i_cfg_idx,
    input logic [gpt_pkg::CFG_W-1:0]     i_cfg_data,
    input logic                          start,
    input logic                          busy,
    input logic signed [gpt_pkg::LAT_W-1:0] i_latitude,
    input logic signed [gpt_pkg::LON_W-1:0] i_longitude,
    input logic [gpt_pkg::PRIO_W-1:0]    i_priority_req,
    input logic                          i_last_city,
    input logic                          o_valid,
    input logic [gpt_pkg::OIDX_W-1:0]    o_city_index,
    input logic                          o_is_last,
    input logic [gpt_pkg::DIST_W-1:0]    o_total_distance
);

    a_last_req_starts_tour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_city) |=> busy)
        else $error("tour did not start after last city");

    a_close_ends_tour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> !busy)
        else $error("busy after closing result");

    a_busy_fall_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_is_last))
        else $error("tour ended without closing result");

    a_partial_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_last) |-> (busy && (o_total_distance == '0)))
        else $error("intermediate result malformed");

endmodule

bind greedy_priority_tour_core gpt_chk u_gpt_chk (.*);
